// ===== src/mpr_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot pixel renderer.
package mpr_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int COORD_BITS  = 12;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SAT_W       = PROD_W + 2;
  localparam int ITER_W      = 9;
  localparam int HEIGHT_W    = 13;
  localparam int COLOUR_W    = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ITER_W-1:0]   ITER_CAP   = ITER_W'(256);
  localparam logic [ITER_W-1:0]   RED_BASE   = ITER_W'(64);
  localparam logic [PROD_W-1:0]   ESC_LIMIT  = PROD_W'(4) << (2 * FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_START      = 3'd0,
    CFG_X_STEP       = 3'd1,
    CFG_Y_START      = 3'd2,
    CFG_Y_STEP       = 3'd3,
    CFG_MAX_ITER     = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [ITER_W-1:0]     iterations;
    logic [COLOUR_W-1:0]   red;
    logic [COLOUR_W-1:0]   green;
    logic [COLOUR_W-1:0]   blue;
    logic [COORD_BITS-1:0] mirror_row;
  } result_t;

  // one queued pixel: point c and its mirrored row
  typedef struct packed {
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
    logic [COORD_BITS-1:0]    mirror_row;
  } job_t;

  // clamp a wide signed value to the signed data range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-DATA_W:0] upper;
    upper = v[SAT_W-1:DATA_W-1];
    if ((&upper) || !(|upper)) begin
      return v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== src/mpr_front.sv =====
// Front end: takes a pixel, forms point c and the mirrored row, pushes a job.
module mpr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mpr_pkg::pixel_t               pixel_i,
  input  logic signed [mpr_pkg::DATA_W-1:0] x_start_i,
  input  logic signed [mpr_pkg::DATA_W-1:0] x_step_i,
  input  logic signed [mpr_pkg::DATA_W-1:0] y_start_i,
  input  logic signed [mpr_pkg::DATA_W-1:0] y_step_i,
  input  logic [mpr_pkg::HEIGHT_W-1:0]  image_height_i,
  input  logic                          full_i,
  output logic                          push_o,
  output mpr_pkg::job_t                 job_o
);
  import mpr_pkg::*;

  localparam int MIR_W = HEIGHT_W + COORD_BITS;

  logic                                  fe_valid_q;
  pixel_t                                pix_q;
  logic signed [COORD_BITS:0]            col_ext, row_ext;
  logic signed [COORD_BITS+DATA_W:0]     prod_r, prod_i;
  logic signed [SAT_W-1:0]               sum_r, sum_i;
  logic [MIR_W-1:0]                      mir_full;
  logic                                  accept;

  assign busy   = fe_valid_q | full_i;
  assign accept = start & ~busy;
  assign push_o = fe_valid_q & ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else if (accept) begin
      fe_valid_q <= 1'b1;
    end else if (push_o) begin
      fe_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_i;
    end
  end

  // c = start + index * step, exact then clamped
  assign col_ext = $signed({1'b0, pix_q.column});
  assign row_ext = $signed({1'b0, pix_q.row});
  assign prod_r  = col_ext * x_step_i;
  assign prod_i  = row_ext * y_step_i;
  assign sum_r   = SAT_W'(prod_r) + SAT_W'(x_start_i);
  assign sum_i   = SAT_W'(prod_i) + SAT_W'(y_start_i);

  // wraps modulo the row width when the row lies outside the image
  assign mir_full = MIR_W'(image_height_i) - MIR_W'(1) - MIR_W'(pix_q.row);

  assign job_o.cr         = sat_data(sum_r);
  assign job_o.ci         = sat_data(sum_i);
  assign job_o.mirror_row = mir_full[COORD_BITS-1:0];

endmodule

// ===== src/mpr_queue.sv =====
// Short job queue between front end and iteration engine.
module mpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mpr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mpr_pkg::job_t job_o
);
  import mpr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t               mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + PTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/mpr_back.sv =====
// Iteration engine: z = z^2 + c on a shared three-product unit, then colour.
module mpr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  mpr_pkg::job_t               job_i,
  output logic                        pop_o,
  input  logic [mpr_pkg::ITER_W-1:0]  limit_i,
  output logic                        valid_o,
  output mpr_pkg::result_t            result_o
);
  import mpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic signed [DATA_W-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic signed [PROD_W-1:0]  pr_q, pi_q, pm_q;
  logic [ITER_W-1:0]         n_q, n_inc, fin_n, half;
  logic [ITER_W-1:0]         red_w;
  logic                      first_q;
  logic [COORD_BITS-1:0]     mir_q;
  logic                      valid_q;
  result_t                   res_q;
  logic [PROD_W-1:0]         sq_sum;
  logic                      esc, fin, in_set;
  logic signed [SAT_W-1:0]   nr_w, ni_w;

  assign pop_o = (state_q == ST_IDLE) & ~empty_i;

  // escape test on the squares of the current z
  assign sq_sum = $unsigned(pr_q) + $unsigned(pi_q);
  assign esc    = (sq_sum > ESC_LIMIT);
  assign n_inc  = n_q + ITER_W'(1);

  assign nr_w = SAT_W'(pr_q >>> FRAC_BITS) - SAT_W'(pi_q >>> FRAC_BITS) + SAT_W'(cr_q);
  assign ni_w = SAT_W'(pm_q >>> (FRAC_BITS - 1)) + SAT_W'(ci_q);

  always_comb begin
    fin   = 1'b0;
    fin_n = n_q;
    if (state_q == ST_UPD) begin
      if (first_q) begin
        fin = (limit_i == '0);
      end else if (esc) begin
        fin = 1'b1;
      end else if (n_inc == limit_i) begin
        fin   = 1'b1;
        fin_n = n_inc;
      end
    end
  end

  assign in_set = (fin_n == limit_i);
  assign half   = fin_n >> 1;
  assign red_w  = RED_BASE + half;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = fin ? ST_IDLE : ST_MUL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cr_q    <= job_i.cr;
      ci_q    <= job_i.ci;
      zr_q    <= job_i.cr;
      zi_q    <= job_i.ci;
      mir_q   <= job_i.mirror_row;
      n_q     <= '0;
      first_q <= 1'b1;
    end
    if (state_q == ST_MUL) begin
      pr_q <= zr_q * zr_q;
      pi_q <= zi_q * zi_q;
      pm_q <= zr_q * zi_q;
    end
    if (state_q == ST_UPD) begin
      if (fin) begin
        res_q.iterations <= fin_n;
        res_q.red        <= in_set ? '0 : red_w[COLOUR_W-1:0];
        res_q.green      <= in_set ? '0 : half[COLOUR_W-1:0];
        res_q.blue       <= in_set ? '0 : fin_n[COLOUR_W-1:0];
        res_q.mirror_row <= mir_q;
      end else begin
        zr_q    <= sat_data(nr_w);
        zi_q    <= sat_data(ni_w);
        n_q     <= first_q ? n_q : n_inc;
        first_q <= 1'b0;
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== src/mandelbrot_pixel_renderer.sv =====
// Top level of the Mandelbrot escape-time pixel renderer.
//
// A pixel beat is taken when start is high and busy is low; exactly one
// result beat follows, shown for a single cycle with valid_o high, and it
// must be taken then, since the receiver has no way to hold it off. The
// front end holds one pixel at a time in a register while it forms c, and a
// two-entry queue lets it take further pixels while the engine works. Each
// iteration of the engine passes through ST_MUL, on the shared three-product
// multiply unit, and then ST_UPD, for add, clamp and escape test; one more
// such pass, not counted, forms the first z. A pixel leaves the queue in
// ST_IDLE, and its result passes through a result register before it is
// shown. Results leave in the order pixels came in.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and must only change while no pixel is in flight.
module mandelbrot_pixel_renderer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mpr_pkg::pixel_t                pixel_i,
  output logic                           valid_o,
  output mpr_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mpr_pkg::DATA_W-1:0]     cfg_data_i
);
  import mpr_pkg::*;

  // reset values: a view of the full set, 450 rows
  localparam logic signed [DATA_W-1:0] X_START_RST = -32'sd536870912;
  localparam logic signed [DATA_W-1:0] X_STEP_RST  = 32'sd1118481;
  localparam logic signed [DATA_W-1:0] Y_START_RST = -32'sd308700774;
  localparam logic signed [DATA_W-1:0] Y_STEP_RST  = 32'sd1372018;
  localparam logic [HEIGHT_W-1:0]      HEIGHT_RST  = HEIGHT_W'(450);

  logic signed [DATA_W-1:0] x_start_q, x_step_q, y_start_q, y_step_q;
  logic [ITER_W-1:0]        max_iter_q, limit;
  logic [HEIGHT_W-1:0]      image_height_q;

  logic  q_push, q_pop, q_full, q_empty;
  job_t  fe_job, q_job;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q      <= X_START_RST;
      x_step_q       <= X_STEP_RST;
      y_start_q      <= Y_START_RST;
      y_step_q       <= Y_STEP_RST;
      max_iter_q     <= ITER_CAP;
      image_height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_START:      x_start_q      <= cfg_data_i;
        CFG_X_STEP:       x_step_q       <= cfg_data_i;
        CFG_Y_START:      y_start_q      <= cfg_data_i;
        CFG_Y_STEP:       y_step_q       <= cfg_data_i;
        CFG_MAX_ITER:     max_iter_q     <= cfg_data_i[ITER_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // limits above the cap behave as the cap
  assign limit = (max_iter_q > ITER_CAP) ? ITER_CAP : max_iter_q;

  mpr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel_i),
    .x_start_i      (x_start_q),
    .x_step_i       (x_step_q),
    .y_start_i      (y_start_q),
    .y_step_i       (y_step_q),
    .image_height_i (image_height_q),
    .full_i         (q_full),
    .push_o         (q_push),
    .job_o          (fe_job)
  );

  mpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (fe_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_job)
  );

  mpr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .job_i    (q_job),
    .pop_o    (q_pop),
    .limit_i  (limit),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // a count never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.iterations <= limit))
    else $error("iteration count above limit");

  // pixels inside the set are black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (result_o.iterations == limit)) |->
      (result_o.red == '0 && result_o.green == '0 && result_o.blue == '0))
    else $error("inside pixel not black");

  // a taken pixel keeps the front end occupied for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("front end free right after a pixel beat");

  // the engine never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
